// ===== design/bilinear_frame_scaler_assert.svh =====
// Assertion macros for the bilinear frame scaler.
// Expects clk_i and rst_ni in the module that includes this header.
`ifndef BILINEAR_FRAME_SCALER_ASSERT_SVH
`define BILINEAR_FRAME_SCALER_ASSERT_SVH
`ifndef SYNTHESIS
`define BFS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define BFS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define BFS_ASSERT(lbl, prop, msg)
`define BFS_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== design/bfs_pkg.sv =====
// Shared constants, types and the pixel blend function of the bilinear scaler.
// No dependencies.
package bfs_pkg;

  localparam int unsigned SCOL_W     = 10;
  localparam int unsigned SROW_W     = 9;
  localparam int unsigned RGB_W      = 24;
  localparam int unsigned DCOL_W     = 12;
  localparam int unsigned DROW_W     = 12;
  localparam int unsigned CFG_W      = 13;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned WT_W       = 8;
  localparam int unsigned IN_TDATA_W = 72;
  localparam int unsigned OUT_TDATA_W = 24;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_READ  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_OUT_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] OUT_WIDTH_RST  = 13'd640;
  localparam logic [CFG_W-1:0] OUT_HEIGHT_RST = 13'd480;

  localparam logic [RGB_W-1:0] RB_MASK = 24'hFF00FF;
  localparam logic [RGB_W-1:0] G_MASK  = 24'h00FF00;

  typedef logic [RGB_W-1:0] rgb_t;
  typedef logic [WT_W-1:0]  wt_t;

  // Blend p toward q by w/256; red and blue ride together in one product.
  function automatic rgb_t mix_pair(rgb_t p, rgb_t q, wt_t w);
    logic [WT_W:0]        s;
    logic [RGB_W+WT_W:0]  rb;
    logic [RGB_W+WT_W:0]  g;
    s  = 9'(9'd256 - 9'(w));
    rb = 33'(p & RB_MASK) * 33'(s) + 33'(q & RB_MASK) * 33'(w);
    g  = 33'(p & G_MASK) * 33'(s) + 33'(q & G_MASK) * 33'(w);
    return (rb[31:8] & RB_MASK) | (g[31:8] & G_MASK);
  endfunction

endpackage

// ===== design/bilinear_frame_scaler.sv =====
// Bilinear frame scaler, top level.
// Path of a read beat: stages 1 and 2, the row divider of NW = 28 +
// clog2(SRC_HEIGHT+1) stages, stages 4 to 6, then the output register.
// Throughput: one beat per cycle, but a write to out_width holds s_axis_tready
// low during the step divide; the pipe halts only while a finished pixel waits.
// Reset clears control and restores 640x480; frame contents stay undefined.
`include "bilinear_frame_scaler_assert.svh"
module bilinear_frame_scaler #(
  parameter int unsigned SRC_WIDTH  = 640,
  parameter int unsigned SRC_HEIGHT = 480
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // src_col[9:0], src_row[18:10], src_rgb[42:19], dst_col[54:43], dst_row[66:55]
  input  logic [bfs_pkg::IN_TDATA_W-1:0] s_axis_tdata,
  // req_type[0]
  input  logic s_axis_tuser,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // out_rgb[23:0]
  output logic [bfs_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic cfg_we_i,
  input  logic [bfs_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [bfs_pkg::CFG_W-1:0] cfg_data_i
);
  localparam int unsigned FW  = bfs_pkg::FRAC_W;
  localparam int unsigned XW  = $clog2(SRC_WIDTH);
  localparam int unsigned YW  = $clog2(SRC_HEIGHT);
  localparam int unsigned SW  = $clog2(SRC_WIDTH + 1) + FW;
  localparam int unsigned PW  = bfs_pkg::DCOL_W + SW;
  localparam int unsigned NW  = bfs_pkg::DROW_W + 1 + $clog2(SRC_HEIGHT + 1) + FW - 1;
  localparam int unsigned CXW = XW + FW;
  localparam int unsigned CYW = YW + FW;
  localparam int unsigned HALF_W = (SRC_WIDTH + 1) / 2;
  localparam int unsigned HALF_H = (SRC_HEIGHT + 1) / 2;
  localparam int unsigned BANK_D = HALF_W * HALF_H;
  localparam int unsigned AW  = (BANK_D > 1) ? $clog2(BANK_D) : 1;
  localparam int unsigned TW  = 1 + bfs_pkg::SCOL_W + bfs_pkg::SROW_W + bfs_pkg::RGB_W + CXW;
  localparam logic [SW-1:0]  NUM_X    = SW'(SRC_WIDTH * 65536);
  localparam logic [SW-1:0]  STEP_RST =
    SW'((SRC_WIDTH * 65536) / int'(bfs_pkg::OUT_WIDTH_RST));
  localparam logic [CXW-1:0] CX_MAX = CXW'((SRC_WIDTH - 1) * 65536);
  localparam logic [CYW-1:0] CY_MAX = CYW'((SRC_HEIGHT - 1) * 65536);

  // Flat bank address of a pixel inside its parity bank.
  function automatic logic [AW-1:0] bank_addr(logic [31:0] c, logic [31:0] r);
    logic [31:0] full;
    full = (r >> 1) * HALF_W + (c >> 1);
    return full[AW-1:0];
  endfunction

  // ---------------- configuration ----------------
  logic [bfs_pkg::CFG_W-1:0] out_height_q;
  logic [bfs_pkg::CFG_W-1:0] h_eff;
  logic [bfs_pkg::CFG_W-1:0] w_new;
  logic                      step_start;
  logic                      step_busy;
  logic [SW-1:0]             step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_height_q <= bfs_pkg::OUT_HEIGHT_RST;
    end else if (cfg_we_i && (cfg_idx_i == bfs_pkg::CFG_OUT_HEIGHT)) begin
      out_height_q <= cfg_data_i;
    end
  end

  // A zero size acts as one.
  assign h_eff      = (out_height_q == '0) ? bfs_pkg::CFG_W'(1) : out_height_q;
  assign w_new      = (cfg_data_i == '0) ? bfs_pkg::CFG_W'(1) : cfg_data_i;
  assign step_start = cfg_we_i && (cfg_idx_i == bfs_pkg::CFG_OUT_WIDTH);

  // Horizontal step (SRC_WIDTH << 16) / out_width, recomputed after each out_width write.
  bfs_step_div #(
    .SW(SW), .DW(bfs_pkg::CFG_W), .NUM(NUM_X), .RST_STEP(STEP_RST)
  ) u_step_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(step_start),
    .div_i  (w_new),
    .busy_o (step_busy),
    .step_o (step_q)
  );

  // ---------------- pipeline control ----------------
  // The whole pipe advances together; it halts only when a finished pixel
  // waits in the output register and another read sits right behind it.
  logic pipe_en;
  logic accept;
  logic v6_q;
  logic typ6_q;
  logic out_valid_q;
  bfs_pkg::rgb_t out_rgb_q;
  logic res_load;

  assign res_load = v6_q && (typ6_q == bfs_pkg::REQ_READ);
  assign pipe_en = !out_valid_q || m_axis_tready || !res_load;
  assign s_axis_tready = pipe_en && !step_busy;
  assign accept = s_axis_tvalid && s_axis_tready;

  // ---------------- stage 1: capture beat ----------------
  logic                        v1_q, typ1_q;
  logic [bfs_pkg::SCOL_W-1:0]  wcol1_q;
  logic [bfs_pkg::SROW_W-1:0]  wrow1_q;
  bfs_pkg::rgb_t               wrgb1_q;
  logic [bfs_pkg::DCOL_W-1:0]  dcol1_q;
  logic [bfs_pkg::DROW_W-1:0]  drow1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (pipe_en) begin
      v1_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      typ1_q  <= s_axis_tuser;
      wcol1_q <= s_axis_tdata[9:0];
      wrow1_q <= s_axis_tdata[18:10];
      wrgb1_q <= s_axis_tdata[42:19];
      dcol1_q <= s_axis_tdata[54:43];
      drow1_q <= s_axis_tdata[66:55];
    end
  end

  // ---------------- stage 2: column product, row numerator ----------------
  logic                        v2_q, typ2_q;
  logic [bfs_pkg::SCOL_W-1:0]  wcol2_q;
  logic [bfs_pkg::SROW_W-1:0]  wrow2_q;
  bfs_pkg::rgb_t               wrgb2_q;
  logic [PW-1:0]               prod2_q;
  logic [NW-1:0]               num2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (pipe_en) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      typ2_q  <= typ1_q;
      wcol2_q <= wcol1_q;
      wrow2_q <= wrow1_q;
      wrgb2_q <= wrgb1_q;
      prod2_q <= PW'(dcol1_q) * PW'(step_q);
      // (2*row + 1) * SRC_HEIGHT << 15, divided by out_height downstream.
      num2_q  <= NW'(NW'({drow1_q, 1'b1}) * NW'(SRC_HEIGHT)) << (FW - 1);
    end
  end

  // Horizontal position: step/2 - 1/2 + col*step, clamped to the frame.
  logic [PW:0]    sum_x, ofs_x;
  logic [CXW-1:0] cx2;

  always_comb begin
    sum_x = (PW+1)'(prod2_q) + (PW+1)'(step_q >> 1);
    ofs_x = sum_x - (PW+1)'(1 << (FW - 1));
    if (sum_x < (PW+1)'(1 << (FW - 1))) begin
      cx2 = '0;
    end else if (ofs_x > (PW+1)'(CX_MAX)) begin
      cx2 = CX_MAX;
    end else begin
      cx2 = ofs_x[CXW-1:0];
    end
  end

  // ---------------- row divider ----------------
  logic                        dv;
  logic [NW-1:0]               dq;
  logic [TW-1:0]               dt;
  logic                        d_typ;
  logic [bfs_pkg::SCOL_W-1:0]  d_wcol;
  logic [bfs_pkg::SROW_W-1:0]  d_wrow;
  bfs_pkg::rgb_t               d_wrgb;
  logic [CXW-1:0]              d_cx;

  bfs_row_div #(.NW(NW), .DW(bfs_pkg::CFG_W), .TW(TW)) u_row_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (pipe_en),
    .valid_i(v2_q),
    .num_i  (num2_q),
    .div_i  (h_eff),
    .tag_i  ({typ2_q, wcol2_q, wrow2_q, wrgb2_q, cx2}),
    .valid_o(dv),
    .quot_o (dq),
    .tag_o  (dt)
  );

  assign {d_typ, d_wcol, d_wrow, d_wrgb, d_cx} = dt;

  // ---------------- stage 4: neighbors, weights, bank addresses ----------------
  logic [NW-1:0]         ofs_y;
  logic [CYW-1:0]        cy;
  logic [XW-1:0]         x0, x1, ecol, ocol;
  logic [YW-1:0]         y0, y1, erow, orow;
  logic [3:0][AW-1:0]    raddr_d;
  logic                  we_d;

  always_comb begin
    ofs_y = dq - NW'(1 << (FW - 1));
    if (dq < NW'(1 << (FW - 1))) begin
      cy = '0;
    end else if (ofs_y > NW'(CY_MAX)) begin
      cy = CY_MAX;
    end else begin
      cy = ofs_y[CYW-1:0];
    end
    x0 = d_cx[CXW-1:FW];
    y0 = cy[CYW-1:FW];
    // Repeat the last column and row.
    x1 = (x0 == XW'(SRC_WIDTH - 1)) ? x0 : XW'(x0 + 1'b1);
    y1 = (y0 == YW'(SRC_HEIGHT - 1)) ? y0 : YW'(y0 + 1'b1);
    ecol = x0[0] ? x1 : x0;
    ocol = x0[0] ? x0 : x1;
    erow = y0[0] ? y1 : y0;
    orow = y0[0] ? y0 : y1;
    for (int b = 0; b < 4; b++) begin
      raddr_d[b] = bank_addr(32'(b[0] ? ocol : ecol), 32'(b[1] ? orow : erow));
    end
    // Drop writes that fall outside the frame.
    we_d = dv && (d_typ == bfs_pkg::REQ_WRITE)
         && (32'(d_wcol) < SRC_WIDTH) && (32'(d_wrow) < SRC_HEIGHT);
  end

  logic                 v4_q, typ4_q, we4_q;
  logic [3:0][AW-1:0]   raddr4_q;
  logic [1:0]           wbank4_q;
  logic [AW-1:0]        waddr4_q;
  bfs_pkg::rgb_t        wrgb4_q;
  logic [3:0]           par4_q;  // y1, y0, x1, x0 parities
  bfs_pkg::wt_t         wx4_q, wy4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q  <= 1'b0;
      we4_q <= 1'b0;
    end else if (pipe_en) begin
      v4_q  <= dv;
      we4_q <= we_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      typ4_q   <= d_typ;
      raddr4_q <= raddr_d;
      wbank4_q <= {d_wrow[0], d_wcol[0]};
      waddr4_q <= bank_addr(32'(d_wcol), 32'(d_wrow));
      wrgb4_q  <= d_wrgb;
      par4_q   <= {y1[0], y0[0], x1[0], x0[0]};
      wx4_q    <= d_cx[FW-1:FW-bfs_pkg::WT_W];
      wy4_q    <= cy[FW-1:FW-bfs_pkg::WT_W];
    end
  end

  // ---------------- stage 5: frame read / write ----------------
  // Reads and writes meet the store in one stage, so beat order is kept.
  logic [3:0][bfs_pkg::RGB_W-1:0] rdata;

  bfs_frame_mem #(.AW(AW), .DEPTH(BANK_D)) u_frame_mem (
    .clk_i  (clk_i),
    .en_i   (pipe_en),
    .we_i   (we4_q),
    .wbank_i(wbank4_q),
    .waddr_i(waddr4_q),
    .wdata_i(wrgb4_q),
    .raddr_i(raddr4_q),
    .rdata_o(rdata)
  );

  logic          v5_q, typ5_q;
  logic [3:0]    par5_q;
  bfs_pkg::wt_t  wx5_q, wy5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (pipe_en) begin
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      typ5_q <= typ4_q;
      par5_q <= par4_q;
      wx5_q  <= wx4_q;
      wy5_q  <= wy4_q;
    end
  end

  // ---------------- stage 6: horizontal blends ----------------
  bfs_pkg::rgb_t px_a, px_b, px_c, px_d;
  bfs_pkg::rgb_t top6_q, bot6_q;
  bfs_pkg::wt_t  wy6_q;

  assign px_a = rdata[{par5_q[2], par5_q[0]}];
  assign px_b = rdata[{par5_q[2], par5_q[1]}];
  assign px_c = rdata[{par5_q[3], par5_q[0]}];
  assign px_d = rdata[{par5_q[3], par5_q[1]}];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
    end else if (pipe_en) begin
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      typ6_q <= typ5_q;
      top6_q <= bfs_pkg::mix_pair(px_a, px_b, wx5_q);
      bot6_q <= bfs_pkg::mix_pair(px_c, px_d, wx5_q);
      wy6_q  <= wy5_q;
    end
  end

  // ---------------- output register: vertical blend ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pipe_en && res_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en && res_load) begin
      out_rgb_q <= bfs_pkg::mix_pair(top6_q, bot6_q, wy6_q);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_rgb_q;

  // ---------------- assertions ----------------
  `BFS_ASSERT(a_no_beat_while_step, !(step_busy && s_axis_tready), "beat taken in step divide")
  `BFS_ASSERT(a_result_lands, (pipe_en && res_load) |=> out_valid_q, "read result lost")
  `BFS_ASSERT(a_stall_holds, !pipe_en |=> (out_valid_q && $stable(out_rgb_q)), "result moved")
  `BFS_ASSERT_ALWAYS(a_idle_in_reset, !rst_ni |=> !m_axis_tvalid, "output valid in reset")
endmodule

// ===== design/bfs_step_div.sv =====
// Iterative divider for the horizontal source step, one quotient bit a cycle.
// No package dependency; widths are passed in by parameter.
module bfs_step_div #(
  parameter int unsigned SW = 26,
  parameter int unsigned DW = 13,
  parameter logic [SW-1:0] NUM = '0,
  parameter logic [SW-1:0] RST_STEP = '0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] div_i,
  output logic          busy_o,
  output logic [SW-1:0] step_o
);
  localparam int unsigned CW = $clog2(SW + 1);

  logic          busy_q, busy_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [SW-1:0] step_q, step_d;
  logic [DW-1:0] rem_q, rem_d;
  logic [SW-1:0] wrd_q, wrd_d;
  logic [DW-1:0] div_q, div_d;
  logic [DW:0]   trial;
  logic          fits;

  always_comb begin
    trial  = {rem_q, wrd_q[SW-1]};
    fits   = trial >= {1'b0, div_q};
    busy_d = busy_q;
    cnt_d  = cnt_q;
    step_d = step_q;
    rem_d  = rem_q;
    wrd_d  = wrd_q;
    div_d  = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(SW);
      rem_d  = '0;
      wrd_d  = NUM;
      div_d  = div_i;
    end else if (busy_q) begin
      rem_d = fits ? DW'(trial - {1'b0, div_q}) : trial[DW-1:0];
      wrd_d = {wrd_q[SW-2:0], fits};
      cnt_d = CW'(cnt_q - 1'b1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        step_d = {wrd_q[SW-2:0], fits};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      step_q <= RST_STEP;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    wrd_q <= wrd_d;
    div_q <= div_d;
  end

  assign busy_o = busy_q;
  assign step_o = step_q;
endmodule

// ===== design/bfs_row_div.sv =====
// Pipelined restoring divider for the vertical source position, one bit a stage.
// Carries an opaque tag beside each quotient; no package dependency.
module bfs_row_div #(
  parameter int unsigned NW = 37,
  parameter int unsigned DW = 13,
  parameter int unsigned TW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] div_i,
  input  logic [TW-1:0] tag_i,
  output logic          valid_o,
  output logic [NW-1:0] quot_o,
  output logic [TW-1:0] tag_o
);
  logic [NW-1:0] vld_q;
  logic [DW-1:0] rem_q [NW];
  logic [NW-1:0] wrd_q [NW];
  logic [TW-1:0] tag_q [NW];

  for (genvar i = 0; i < NW; i++) begin : g_stage
    logic          vld_in;
    logic [DW-1:0] rem_in;
    logic [NW-1:0] wrd_in;
    logic [TW-1:0] tag_in;
    logic [DW:0]   trial;
    logic          fits;

    if (i == 0) begin : g_head
      assign vld_in = valid_i;
      assign rem_in = '0;
      assign wrd_in = num_i;
      assign tag_in = tag_i;
    end else begin : g_body
      assign vld_in = vld_q[i-1];
      assign rem_in = rem_q[i-1];
      assign wrd_in = wrd_q[i-1];
      assign tag_in = tag_q[i-1];
    end

    assign trial = {rem_in, wrd_in[NW-1]};
    assign fits  = trial >= {1'b0, div_i};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (en_i) begin
        vld_q[i] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i] <= fits ? DW'(trial - {1'b0, div_i}) : trial[DW-1:0];
        wrd_q[i] <= {wrd_in[NW-2:0], fits};
        tag_q[i] <= tag_in;
      end
    end
  end

  assign valid_o = vld_q[NW-1];
  assign quot_o  = wrd_q[NW-1];
  assign tag_o   = tag_q[NW-1];
endmodule

// ===== design/bfs_frame_mem.sv =====
// Source frame store: four banks split by row and column parity, one read port each.
// Uses bfs_pkg for the pixel type.
module bfs_frame_mem #(
  parameter int unsigned AW    = 17,
  parameter int unsigned DEPTH = 76800
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic                    we_i,
  input  logic [1:0]              wbank_i,
  input  logic [AW-1:0]           waddr_i,
  input  bfs_pkg::rgb_t           wdata_i,
  input  logic [3:0][AW-1:0]      raddr_i,
  output logic [3:0][bfs_pkg::RGB_W-1:0] rdata_o
);
  for (genvar b = 0; b < 4; b++) begin : g_bank
    bfs_pkg::rgb_t bank_mem [DEPTH];
    bfs_pkg::rgb_t rd_q;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (we_i && (wbank_i == 2'(b))) begin
          bank_mem[waddr_i] <= wdata_i;
        end
        rd_q <= bank_mem[raddr_i[b]];
      end
    end

    assign rdata_o[b] = rd_q;
  end
endmodule

// ===== sim/bilinear_frame_scaler_tb.sv =====
// Self-checking testbench for bilinear_frame_scaler: directed table, then random phases.
// Depends on bfs_pkg and bilinear_frame_scaler RTL; predicts outputs not fixed by hand.
module bilinear_frame_scaler_tb;

  localparam int unsigned SRC_W     = 640;
  localparam int unsigned SRC_H     = 480;
  localparam int unsigned DRAIN_CYC = 80;
  localparam int unsigned STALL_MAX = 13;
  localparam int unsigned HOLD_CYC  = 400;   // long receiver hold-off
  localparam int unsigned WDOG_MAX  = 5000;
  localparam int unsigned N_RANDOM  = 1330;
  localparam int unsigned N_PHASES  = 7;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  // src_col[9:0], src_row[18:10], src_rgb[42:19], dst_col[54:43], dst_row[66:55]
  logic [bfs_pkg::IN_TDATA_W-1:0] s_axis_tdata = '0;
  // req_type[0]
  logic s_axis_tuser = bfs_pkg::REQ_WRITE;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  // out_rgb[23:0]
  logic [bfs_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic cfg_we_i = 1'b0;
  logic [bfs_pkg::CFG_IDX_W-1:0] cfg_idx_i = bfs_pkg::CFG_OUT_WIDTH;
  logic [bfs_pkg::CFG_W-1:0] cfg_data_i = '0;

  bilinear_frame_scaler #(.SRC_WIDTH(SRC_W), .SRC_HEIGHT(SRC_H)) i_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Shadow of the source frame, updated on accepted beats, and of the output size.
  bfs_pkg::rgb_t frame_px [SRC_W*SRC_H];
  bit   frame_set [SRC_W*SRC_H];
  logic [bfs_pkg::CFG_W-1:0] width_reg = bfs_pkg::OUT_WIDTH_RST;
  logic [bfs_pkg::CFG_W-1:0] height_reg = bfs_pkg::OUT_HEIGHT_RST;

  bfs_pkg::rgb_t expected_rgb [$];
  int unsigned mismatch_cnt = 0;
  int unsigned beat_cnt = 0;
  bit failed = 1'b0;
  bit hold_req = 1'b0;
  bit src_burst = 1'b0;
  bit dst_burst = 1'b0;

  // Work out the 16.16 source position of an output pixel: taps and weights.
  task automatic find_taps(input logic [bfs_pkg::DCOL_W-1:0] dcol,
                           input logic [bfs_pkg::DROW_W-1:0] drow,
                           output int x0, output int x1, output int y0, output int y1,
                           output int wx, output int wy);
    longint w, h, step, fx, fy;
    w    = (width_reg == 0) ? 1 : longint'(width_reg);
    h    = (height_reg == 0) ? 1 : longint'(height_reg);
    step = (longint'(SRC_W) << 16) / w;
    fx   = (longint'(SRC_W) << 15) / w - (64'sd1 << 15) + longint'(dcol) * step;
    fy   = (((2 * longint'(drow) + 1) * SRC_H) << 15) / h - (64'sd1 << 15);
    if (fx < 0) fx = 0;
    if (fx > (longint'(SRC_W - 1) << 16)) fx = longint'(SRC_W - 1) << 16;
    if (fy < 0) fy = 0;
    if (fy > (longint'(SRC_H - 1) << 16)) fy = longint'(SRC_H - 1) << 16;
    x0 = int'(fx >> 16);
    y0 = int'(fy >> 16);
    x1 = (x0 + 1 < SRC_W) ? x0 + 1 : x0;
    y1 = (y0 + 1 < SRC_H) ? y0 + 1 : y0;
    wx = int'((fx >> 8) & 255);
    wy = int'((fy >> 8) & 255);
  endtask

  // Blend two pixels, red and blue in one product and green alone.
  function automatic bfs_pkg::rgb_t blend(bfs_pkg::rgb_t p, bfs_pkg::rgb_t q, int wq);
    longint rb, g;
    rb = (longint'(p & bfs_pkg::RB_MASK) * (256 - wq)
          + longint'(q & bfs_pkg::RB_MASK) * wq) >> 8;
    g  = (longint'(p & bfs_pkg::G_MASK) * (256 - wq)
          + longint'(q & bfs_pkg::G_MASK) * wq) >> 8;
    return bfs_pkg::rgb_t'(rb & longint'(bfs_pkg::RB_MASK))
         | bfs_pkg::rgb_t'(g & longint'(bfs_pkg::G_MASK));
  endfunction

  task automatic predict_pixel(input logic [bfs_pkg::DCOL_W-1:0] dcol,
                               input logic [bfs_pkg::DROW_W-1:0] drow,
                               output bfs_pkg::rgb_t px);
    int x0, x1, y0, y1, wx, wy;
    bfs_pkg::rgb_t top, bot;
    find_taps(dcol, drow, x0, x1, y0, y1, wx, wy);
    top = blend(frame_px[y0*SRC_W+x0], frame_px[y0*SRC_W+x1], wx);
    bot = blend(frame_px[y1*SRC_W+x0], frame_px[y1*SRC_W+x1], wx);
    px  = blend(top, bot, wy);
  endtask

  // Offer one beat after a random gap, hold it until accepted; update shadow or expected queue.
  task automatic send_beat(input logic req, input logic [bfs_pkg::SCOL_W-1:0] col,
                           input logic [bfs_pkg::SROW_W-1:0] row, input bfs_pkg::rgb_t rgb,
                           input logic [bfs_pkg::DCOL_W-1:0] dcol,
                           input logic [bfs_pkg::DROW_W-1:0] drow,
                           input bit fixed, input bfs_pkg::rgb_t fixed_rgb);
    int unsigned gap;
    bfs_pkg::rgb_t px;
    if ($urandom_range(0, 24) == 0) src_burst = !src_burst;
    gap = src_burst ? 0 : $urandom_range(0, STALL_MAX);
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tuser  = req;
    s_axis_tdata  = {5'b0, drow, dcol, rgb, row, col};
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    beat_cnt++;
    if (req == bfs_pkg::REQ_WRITE) begin
      if (col < SRC_W && row < SRC_H) begin
        frame_px[int'(row)*SRC_W+int'(col)]  = rgb;
        frame_set[int'(row)*SRC_W+int'(col)] = 1'b1;
      end
    end else begin
      predict_pixel(dcol, drow, px);
      expected_rgb.push_back(fixed ? fixed_rgb : px);
    end
  endtask

  task automatic put_pixel(input int col, input int row);
    send_beat(bfs_pkg::REQ_WRITE, bfs_pkg::SCOL_W'(col), bfs_pkg::SROW_W'(row),
              bfs_pkg::rgb_t'($urandom), '0, '0, 1'b0, '0);
  endtask

  // Issue a read; fill any never-written neighbor first so no undefined entry is fetched.
  task automatic read_pixel(input logic [bfs_pkg::DCOL_W-1:0] dcol,
                            input logic [bfs_pkg::DROW_W-1:0] drow,
                            input bit fixed, input bfs_pkg::rgb_t fixed_rgb);
    int x0, x1, y0, y1, wx, wy;
    find_taps(dcol, drow, x0, x1, y0, y1, wx, wy);
    if (!frame_set[y0*SRC_W+x0]) put_pixel(x0, y0);
    if (!frame_set[y0*SRC_W+x1]) put_pixel(x1, y0);
    if (!frame_set[y1*SRC_W+x0]) put_pixel(x0, y1);
    if (!frame_set[y1*SRC_W+x1]) put_pixel(x1, y1);
    send_beat(bfs_pkg::REQ_READ, bfs_pkg::SCOL_W'($urandom), bfs_pkg::SROW_W'($urandom),
              bfs_pkg::rgb_t'($urandom), dcol, drow, fixed, fixed_rgb);
  endtask

  task automatic write_reg(input logic [bfs_pkg::CFG_IDX_W-1:0] idx,
                           input logic [bfs_pkg::CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == bfs_pkg::CFG_OUT_WIDTH) width_reg = val;
    else height_reg = val;
  endtask

  // Drop valid, wait for every expected pixel, then let the pipeline settle.
  task automatic drain;
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (expected_rgb.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYC) @(negedge clk_i);
  endtask

  typedef struct {
    logic                         req;
    logic [bfs_pkg::SCOL_W-1:0]   col;
    logic [bfs_pkg::SROW_W-1:0]   row;
    bfs_pkg::rgb_t                rgb;
    logic [bfs_pkg::DCOL_W-1:0]   dcol;
    logic [bfs_pkg::DROW_W-1:0]   drow;
    bit                           fixed;
    bfs_pkg::rgb_t                fixed_rgb;
  } dir_row_t;

  // Directed table at the reset size 640x480; fixed values are read off by hand.
  dir_row_t dir_tab [19] = '{
    '{bfs_pkg::REQ_WRITE,   0,   0, 24'hFFFFFF,    0,    0, 0, 0},
    '{bfs_pkg::REQ_WRITE,   1,   0, 24'hFFFFFF,    0,    0, 0, 0},
    '{bfs_pkg::REQ_WRITE,   0,   1, 24'hFFFFFF,    0,    0, 0, 0},
    '{bfs_pkg::REQ_WRITE,   1,   1, 24'hFFFFFF,    0,    0, 0, 0},
    '{bfs_pkg::REQ_READ,    0,   0, 24'h000000,    0,    0, 1, 24'hFFFFFF},  // top-left
    '{bfs_pkg::REQ_WRITE, 639, 479, 24'h123456,    0,    0, 0, 0},
    '{bfs_pkg::REQ_WRITE, 638, 479, 24'h123456,    0,    0, 0, 0},
    '{bfs_pkg::REQ_WRITE, 639, 478, 24'h123456,    0,    0, 0, 0},
    '{bfs_pkg::REQ_WRITE, 638, 478, 24'h123456,    0,    0, 0, 0},
    '{bfs_pkg::REQ_READ,    0,   0, 24'h000000,  639,  479, 1, 24'h123456},  // last row/col
    '{bfs_pkg::REQ_READ,    0,   0, 24'h000000, 4095, 4095, 1, 24'h123456},  // clamps
    '{bfs_pkg::REQ_WRITE,1023, 511, 24'h000000,    0,    0, 0, 0},           // outside: drop
    '{bfs_pkg::REQ_WRITE, 639, 511, 24'hABCDEF,    0,    0, 0, 0},
    '{bfs_pkg::REQ_WRITE,1023, 479, 24'hABCDEF,    0,    0, 0, 0},
    '{bfs_pkg::REQ_READ,    0,   0, 24'h000000,  639,  479, 1, 24'h123456},  // untouched
    '{bfs_pkg::REQ_READ,    0,   0, 24'h000000,  320,  240, 0, 0},
    '{bfs_pkg::REQ_READ,    0,   0, 24'h000000,    1,    0, 0, 0},
    '{bfs_pkg::REQ_WRITE,   0,   0, 24'h000000,    0,    0, 0, 0},
    '{bfs_pkg::REQ_READ,    0,   0, 24'h000000,    0,    0, 1, 24'h000000}
  };

  // Output sizes per phase: extremes, zero, above range, then random ones.
  logic [bfs_pkg::CFG_W-1:0] phase_w [N_PHASES] = '{640, 1, 4096, 8191, 0, 1280, 17};
  logic [bfs_pkg::CFG_W-1:0] phase_h [N_PHASES] = '{480, 1, 4096, 0, 8191, 960, 33};

  initial begin
    int unsigned per_phase, sent, eff_w, eff_h;
    logic [bfs_pkg::DCOL_W-1:0] dcol;
    logic [bfs_pkg::DROW_W-1:0] drow;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].req == bfs_pkg::REQ_WRITE)
        send_beat(bfs_pkg::REQ_WRITE, dir_tab[i].col, dir_tab[i].row, dir_tab[i].rgb,
                  bfs_pkg::DCOL_W'($urandom), bfs_pkg::DROW_W'($urandom), 1'b0, '0);
      else
        read_pixel(dir_tab[i].dcol, dir_tab[i].drow, dir_tab[i].fixed, dir_tab[i].fixed_rgb);
    end

    per_phase = N_RANDOM / N_PHASES;
    for (int p = 0; p < N_PHASES; p++) begin
      drain();
      if (p >= 5) begin
        phase_w[p] = bfs_pkg::CFG_W'($urandom_range(1, 4096));
        phase_h[p] = bfs_pkg::CFG_W'($urandom_range(1, 4096));
      end
      write_reg(bfs_pkg::CFG_OUT_WIDTH, phase_w[p]);
      write_reg(bfs_pkg::CFG_OUT_HEIGHT, phase_h[p]);
      if (p == 2) hold_req = 1'b1;
      eff_w = (width_reg == 0) ? 1 : 32'(width_reg);
      eff_h = (height_reg == 0) ? 1 : 32'(height_reg);
      // Count every beat, fills included, against the phase budget.
      sent = beat_cnt;
      while (beat_cnt - sent < per_phase) begin
        case ($urandom_range(0, 9))
          0: begin
            // Noise write: any column and row; those outside the frame are dropped by the block.
            send_beat(bfs_pkg::REQ_WRITE, bfs_pkg::SCOL_W'($urandom),
                      bfs_pkg::SROW_W'($urandom), bfs_pkg::rgb_t'($urandom),
                      bfs_pkg::DCOL_W'($urandom), bfs_pkg::DROW_W'($urandom), 1'b0, '0);
          end
          1: begin
            dcol = bfs_pkg::DCOL_W'($urandom);
            drow = bfs_pkg::DROW_W'($urandom);
            read_pixel(dcol, drow, 1'b0, '0);
          end
          default: begin
            dcol = bfs_pkg::DCOL_W'($urandom_range(0, (eff_w > 4096 ? 4096 : eff_w) - 1));
            drow = bfs_pkg::DROW_W'($urandom_range(0, (eff_h > 4096 ? 4096 : eff_h) - 1));
            read_pixel(dcol, drow, 1'b0, '0);
          end
        endcase
      end
    end

    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (expected_rgb.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYC) @(negedge clk_i);
    if (!failed) begin
      $display("PASS bilinear_frame_scaler");
    end else begin
      $display("FAIL bilinear_frame_scaler");
    end
    $finish;
  end

  // Receiver: random stall before each beat, bursts without stalls, one long hold-off.
  initial begin
    int unsigned stall;
    @(negedge clk_i);
    forever begin
      if (hold_req) begin
        m_axis_tready = 1'b0;
        repeat (HOLD_CYC) @(negedge clk_i);
        hold_req = 1'b0;
      end
      if ($urandom_range(0, 24) == 0) dst_burst = !dst_burst;
      stall = dst_burst ? 0 : $urandom_range(0, STALL_MAX);
      if (stall > 0) begin
        m_axis_tready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready = 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      @(negedge clk_i);
    end
  end

  // Compare each output beat with the oldest expected pixel.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_rgb.size() == 0) begin
        failed = 1'b1;
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("unexpected output beat: %06h", m_axis_tdata);
      end else begin
        if (m_axis_tdata !== expected_rgb[0]) begin
          failed = 1'b1;
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("out_rgb mismatch: expected %06h, got %06h", expected_rgb[0],
                     m_axis_tdata);
        end
        void'(expected_rgb.pop_front());
      end
    end
  end

  // Watchdog: end the run when no beat moves on either side for too long.
  int unsigned idle_cyc = 0;
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cyc <= 0;
    end else if (idle_cyc + 1 >= WDOG_MAX) begin
      $display("FAIL bilinear_frame_scaler");
      $finish;
    end else begin
      idle_cyc <= idle_cyc + 1;
    end
  end

endmodule
